// ----- rtl/tcw_pkg.sv -----
// Text console writer package: field widths, operation codes and character constants.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none

package tcw_pkg;

    localparam int OP_W         = 2;
    localparam int CHAR_W       = 8;
    localparam int CELL_INDEX_W = 11;
    localparam int CURSOR_X_W   = 7;
    localparam int CURSOR_Y_W   = 5;
    localparam int CELL_W       = 16;
    localparam int ATTR_W       = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'h7F;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

endpackage

`default_nettype wire

// ----- rtl/tcw_if.sv -----
// Handshake interfaces of the text console writer: command, response and attribute write.
// Depends on tcw_pkg for the field widths.
`default_nettype none

interface tcw_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [tcw_pkg::OP_W-1:0]             op;
    logic [tcw_pkg::CHAR_W-1:0]           char_code;
    logic [tcw_pkg::CELL_INDEX_W-1:0]     cell_index;

    modport source (output valid, output op, output char_code, output cell_index, input ready);
    modport sink   (input valid, input op, input char_code, input cell_index, output ready);
endinterface

interface tcw_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [tcw_pkg::CURSOR_X_W-1:0]       cursor_x;
    logic [tcw_pkg::CURSOR_Y_W-1:0]       cursor_y;
    logic [tcw_pkg::CELL_W-1:0]           cell_data;

    modport source (output valid, output cursor_x, output cursor_y, output cell_data, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, input cell_data, output ready);
endinterface

interface tcw_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [tcw_pkg::ATTR_W-1:0]           text_attribute;

    modport source (output valid, output text_attribute, input ready);
    modport sink   (input valid, input text_attribute, output ready);
endinterface

`default_nettype wire

// ----- rtl/tcw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/text_console_writer.sv -----
// Put, read and unused-op words: accept in ST_IDLE, then ST_DONE registers the response
// once the output word is free; cmd ready is low until then. A put that scrolls adds
// ST_SCR_PRIME and a ST_SCROLL pass over all ROWS*COLUMNS cells (row copy through the
// cell RAM, one cell a cycle); a clear adds a ST_FILL pass (one RAM write a cycle). Reset
// runs a ST_FILL pass that blanks the RAM with 0x0F20, cmd ready low meanwhile; attribute
// writes are always taken. Depends on tcw_pkg, tcw_if and tcw_ram.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    tcw_cmd_if.sink   i_cmd,
    tcw_rsp_if.source o_rsp,
    tcw_cfg_if.sink   i_cfg
);

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELLS);
    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);
    localparam int NCW        = $clog2(COLUMNS + TAB_STOP + 1);
    localparam int PW         = $clog2(TAB_STOP);
    localparam int SCROLL_END = (ROWS - 1) * COLUMNS;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_SCR_PRIME,
        ST_SCROLL,
        ST_DONE
    } t_state;

    t_state                        r_state;
    logic [CW-1:0]                 r_col;
    logic [RW-1:0]                 r_row;
    logic [PW-1:0]                 r_phase;
    logic [tcw_pkg::ATTR_W-1:0]    r_attr;
    logic [AW-1:0]                 r_sweep;
    logic [tcw_pkg::CELL_W-1:0]    r_fill_val;
    logic                          r_fill_rsp;
    logic                          r_in_range;
    logic                          r_out_valid;
    logic [tcw_pkg::CURSOR_X_W-1:0] r_out_x;
    logic [tcw_pkg::CURSOR_Y_W-1:0] r_out_y;
    logic [tcw_pkg::CELL_W-1:0]    r_out_data;

    logic                          accept;
    logic                          printable;
    logic [NCW-1:0]                n_colw;
    logic [CW-1:0]                 n_col;
    logic [RW-1:0]                 n_row;
    logic [PW-1:0]                 n_phase;
    logic                          row_inc;
    logic                          n_scroll;
    logic                          read_in_range;
    logic                          sweep_last;
    logic [AW:0]                   src_next;
    logic [tcw_pkg::CELL_W-1:0]    blank;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]    ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]    ram_rdata;

    assign i_cmd.ready    = (r_state == ST_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign accept         = i_cmd.valid && i_cmd.ready;
    assign printable      = i_cmd.char_code inside {[tcw_pkg::CH_PRINT_LO:tcw_pkg::CH_PRINT_HI]};
    assign read_in_range  = 32'(i_cmd.cell_index) < CELLS;
    assign sweep_last     = (r_sweep == AW'(CELLS - 1));
    assign src_next       = (AW+1)'(r_sweep) + (AW+1)'(COLUMNS + 1);
    assign blank          = {r_attr, tcw_pkg::CH_BLANK};

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.cursor_x  = r_out_x;
    assign o_rsp.cursor_y  = r_out_y;
    assign o_rsp.cell_data = r_out_data;

    // cursor update for a put; r_phase tracks column mod TAB_STOP
    always_comb begin
        n_colw  = NCW'(r_col);
        n_phase = r_phase;
        row_inc = 1'b0;
        case (i_cmd.char_code)
            tcw_pkg::CH_BS: begin
                if (r_col != '0) begin
                    n_colw  = NCW'(r_col) - NCW'(1);
                    n_phase = (r_phase == '0) ? PW'(TAB_STOP - 1) : r_phase - PW'(1);
                end
            end
            tcw_pkg::CH_TAB: begin
                n_colw  = NCW'(r_col) + NCW'(TAB_STOP) - NCW'(r_phase);
                n_phase = '0;
            end
            tcw_pkg::CH_CR: begin
                n_colw  = '0;
                n_phase = '0;
            end
            tcw_pkg::CH_LF: begin
                n_colw  = '0;
                n_phase = '0;
                row_inc = 1'b1;
            end
            default: begin
                if (printable) begin
                    n_colw  = NCW'(r_col) + NCW'(1);
                    n_phase = (r_phase == PW'(TAB_STOP - 1)) ? '0 : r_phase + PW'(1);
                end
            end
        endcase
        if (32'(n_colw) >= COLUMNS) begin
            n_colw  = '0;
            n_phase = '0;
            row_inc = 1'b1;
        end
        n_col    = n_colw[CW-1:0];
        n_scroll = row_inc && (r_row == RW'(ROWS - 1));
        n_row    = (row_inc && !n_scroll) ? r_row + RW'(1) : r_row;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_sweep;
        ram_wdata = r_fill_val;
        ram_re    = 1'b0;
        ram_raddr = AW'(i_cmd.cell_index);
        case (r_state)
            ST_IDLE: begin
                if (accept && i_cmd.op == tcw_pkg::OP_PUT && printable) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(AW'(r_row) * AW'(COLUMNS)) + AW'(r_col);
                    ram_wdata = {r_attr, i_cmd.char_code};
                end
                if (accept && i_cmd.op == tcw_pkg::OP_READ && read_in_range) begin
                    ram_re = 1'b1;
                end
            end
            ST_SCR_PRIME: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(COLUMNS);
            end
            ST_SCROLL: begin
                // write cell r_sweep from the read issued last cycle, read one ahead
                ram_we    = 1'b1;
                ram_wdata = (32'(r_sweep) < SCROLL_END) ? ram_rdata : blank;
                ram_re    = (src_next < (AW+1)'(CELLS));
                ram_raddr = src_next[AW-1:0];
            end
            ST_FILL: begin
                ram_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_sweep     <= '0;
            r_fill_val  <= {tcw_pkg::RESET_ATTR, tcw_pkg::CH_BLANK};
            r_fill_rsp  <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_phase     <= '0;
            r_attr      <= tcw_pkg::RESET_ATTR;
            r_in_range  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_attr <= i_cfg.text_attribute;
            end
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_in_range <= 1'b0;
                        r_state    <= ST_DONE;
                        case (i_cmd.op)
                            tcw_pkg::OP_PUT: begin
                                r_col   <= n_col;
                                r_row   <= n_row;
                                r_phase <= n_phase;
                                if (n_scroll) begin
                                    r_state <= ST_SCR_PRIME;
                                end
                            end
                            tcw_pkg::OP_CLEAR: begin
                                r_col      <= '0;
                                r_row      <= '0;
                                r_phase    <= '0;
                                r_sweep    <= '0;
                                r_fill_val <= blank;
                                r_fill_rsp <= 1'b1;
                                r_state    <= ST_FILL;
                            end
                            tcw_pkg::OP_READ: begin
                                r_in_range <= read_in_range;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCR_PRIME: begin
                    r_sweep <= '0;
                    r_state <= ST_SCROLL;
                end
                ST_SCROLL: begin
                    r_sweep <= r_sweep + AW'(1);
                    if (sweep_last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_FILL: begin
                    r_sweep <= r_sweep + AW'(1);
                    if (sweep_last) begin
                        r_state <= r_fill_rsp ? ST_DONE : ST_IDLE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= tcw_pkg::CURSOR_X_W'(r_col);
                        r_out_y     <= tcw_pkg::CURSOR_Y_W'(r_row);
                        r_out_data  <= r_in_range ? ram_rdata : '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ----- rtl/tcw_checker.sv -----
// Port-level checks for the text console writer, attached to the top level by bind.
// Depends on tcw_pkg and text_console_writer.
`default_nettype none

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 i_cmd_valid,
    input wire                                 i_cmd_ready,
    input wire                                 i_rsp_valid,
    input wire                                 i_rsp_ready,
    input wire [tcw_pkg::CURSOR_X_W-1:0]       i_cursor_x,
    input wire [tcw_pkg::CURSOR_Y_W-1:0]       i_cursor_y,
    input wire [tcw_pkg::CELL_W-1:0]           i_cell_data
);

    // reset starts the blanking pass, so no command word right after it
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_cmd_ready)
        else $error("cmd ready high right after reset");

    // one word in flight: ready drops after each accepted command
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready) |=> !i_cmd_ready)
        else $error("command accepted while another is in work");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (32'(i_cursor_x) < COLUMNS) &&
                        ((ROWS > 32) || (32'(i_cursor_y) < ROWS)))
        else $error("cursor outside the screen");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_cursor_x) && $stable(i_cursor_y) && $stable(i_cell_data)))
        else $error("stalled response word changed");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_cursor_x  (o_rsp.cursor_x),
    .i_cursor_y  (o_rsp.cursor_y),
    .i_cell_data (o_rsp.cell_data)
);

`default_nettype wire

// ----- dv/text_console_writer_test.sv -----
// Self-checking testbench for text_console_writer: directed command table, then random
// text, control, read and clear traffic, checked against typed rows or an in-bench model.
// Depends on tcw_pkg, tcw_if and the text_console_writer RTL.
`default_nettype none

module text_console_writer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STOP   = 8;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam logic [tcw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int PHASES      = 5;
    localparam int PHASE_WORDS = 200;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [tcw_pkg::CURSOR_X_W-1:0] cursor_x;
        logic [tcw_pkg::CURSOR_Y_W-1:0] cursor_y;
        logic [tcw_pkg::CELL_W-1:0]     cell_data;
    } t_console_rsp;

    typedef struct packed {
        logic [tcw_pkg::OP_W-1:0]         op;
        logic [tcw_pkg::CHAR_W-1:0]       ch;
        logic [tcw_pkg::CELL_INDEX_W-1:0] idx;
        logic                             typed;
        t_console_rsp                     rsp;
    } t_stim_row;

    localparam int DIR_ROWS = 25;
    localparam t_stim_row DIRECTED [DIR_ROWS] = '{
        '{tcw_pkg::OP_READ,  8'h00,  11'd0,    1'b1, '{7'd0,  5'd0, 16'h0F20}},
        '{tcw_pkg::OP_READ,  8'hFF,  11'd1999, 1'b1, '{7'd0,  5'd0, 16'h0F20}},
        '{tcw_pkg::OP_READ,  8'h00,  11'd2000, 1'b1, '{7'd0,  5'd0, 16'h0000}},
        '{tcw_pkg::OP_READ,  8'h00,  11'd2047, 1'b1, '{7'd0,  5'd0, 16'h0000}},
        '{OP_UNUSED,         8'hFF,  11'd2047, 1'b1, '{7'd0,  5'd0, 16'h0000}},
        '{tcw_pkg::OP_PUT,   tcw_pkg::CH_BS, 11'd0, 1'b1, '{7'd0,  5'd0, 16'h0000}},
        '{tcw_pkg::OP_PUT,   8'h00,  11'd0,    1'b1, '{7'd0,  5'd0, 16'h0000}},
        '{tcw_pkg::OP_PUT,   8'h1F,  11'd0,    1'b1, '{7'd0,  5'd0, 16'h0000}},
        '{tcw_pkg::OP_PUT,   8'h80,  11'd0,    1'b1, '{7'd0,  5'd0, 16'h0000}},
        '{tcw_pkg::OP_PUT,   8'hFF,  11'd2047, 1'b1, '{7'd0,  5'd0, 16'h0000}},
        '{tcw_pkg::OP_PUT,   8'h41,  11'd0,    1'b1, '{7'd1,  5'd0, 16'h0000}},
        '{tcw_pkg::OP_PUT,   tcw_pkg::CH_PRINT_LO, 11'd0, 1'b1, '{7'd2, 5'd0, 16'h0000}},
        '{tcw_pkg::OP_PUT,   tcw_pkg::CH_PRINT_HI, 11'd0, 1'b1, '{7'd3, 5'd0, 16'h0000}},
        '{tcw_pkg::OP_READ,  8'h00,  11'd0,    1'b1, '{7'd3,  5'd0, 16'h0F41}},
        '{tcw_pkg::OP_READ,  8'h00,  11'd2,    1'b1, '{7'd3,  5'd0, 16'h0F7F}},
        '{tcw_pkg::OP_PUT,   tcw_pkg::CH_BS,  11'd0, 1'b1, '{7'd2,  5'd0, 16'h0000}},
        '{tcw_pkg::OP_PUT,   tcw_pkg::CH_TAB, 11'd0, 1'b1, '{7'd8,  5'd0, 16'h0000}},
        '{tcw_pkg::OP_PUT,   tcw_pkg::CH_TAB, 11'd0, 1'b1, '{7'd16, 5'd0, 16'h0000}},
        '{tcw_pkg::OP_PUT,   tcw_pkg::CH_CR,  11'd0, 1'b1, '{7'd0,  5'd0, 16'h0000}},
        '{tcw_pkg::OP_PUT,   tcw_pkg::CH_LF,  11'd0, 1'b1, '{7'd0,  5'd1, 16'h0000}},
        '{tcw_pkg::OP_PUT,   8'h7E,  11'd2047, 1'b0, '0},
        '{tcw_pkg::OP_READ,  8'h00,  11'd80,   1'b0, '0},
        '{tcw_pkg::OP_CLEAR, 8'hFF,  11'd2047, 1'b1, '{7'd0,  5'd0, 16'h0000}},
        '{tcw_pkg::OP_READ,  8'h00,  11'd80,   1'b1, '{7'd0,  5'd0, 16'h0F20}},
        '{tcw_pkg::OP_READ,  8'h00,  11'd0,    1'b1, '{7'd0,  5'd0, 16'h0F20}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcw_cmd_if cmd_bus ();
    tcw_rsp_if rsp_bus ();
    tcw_cfg_if cfg_bus ();

    text_console_writer #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    always #2 i_clk = ~i_clk;

    // console model state
    logic [tcw_pkg::CELL_W-1:0] screen_copy [CELL_COUNT];
    logic [tcw_pkg::ATTR_W-1:0] model_attr;
    int unsigned                cur_col;
    int unsigned                cur_row;

    t_console_rsp expected_replies [$];

    int mismatch_count;
    int words_sent;
    int phase_words;
    int scroll_count;
    int clear_count;
    int read_count;
    int send_idle_pct;
    int rcv_stall_pct;
    int hold_requests;
    int hold_served = 0;
    int hold_left   = 0;

    function automatic t_console_rsp console_step(logic [tcw_pkg::OP_W-1:0] op,
                                                  logic [tcw_pkg::CHAR_W-1:0] ch,
                                                  logic [tcw_pkg::CELL_INDEX_W-1:0] idx);
        t_console_rsp r;
        r = '0;
        case (op)
            tcw_pkg::OP_PUT: begin
                case (ch)
                    tcw_pkg::CH_BS:  if (cur_col != 0) cur_col--;
                    tcw_pkg::CH_TAB: cur_col = cur_col + TAB_STOP - (cur_col % TAB_STOP);
                    tcw_pkg::CH_CR:  cur_col = 0;
                    tcw_pkg::CH_LF: begin
                        cur_col = 0;
                        cur_row++;
                    end
                    default: begin
                        if (ch >= tcw_pkg::CH_PRINT_LO && ch <= tcw_pkg::CH_PRINT_HI) begin
                            if (cur_row * COLUMNS + cur_col < CELL_COUNT)
                                screen_copy[cur_row * COLUMNS + cur_col] = {model_attr, ch};
                            cur_col++;
                        end
                    end
                endcase
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                        screen_copy[i] = screen_copy[i + COLUMNS];
                    for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++)
                        screen_copy[i] = {model_attr, tcw_pkg::CH_BLANK};
                    cur_row = ROWS - 1;
                    scroll_count++;
                end
            end
            tcw_pkg::OP_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++)
                    screen_copy[i] = {model_attr, tcw_pkg::CH_BLANK};
                cur_col = 0;
                cur_row = 0;
                clear_count++;
            end
            tcw_pkg::OP_READ: begin
                read_count++;
                if (idx < CELL_COUNT)
                    r.cell_data = screen_copy[idx];
            end
            default: ;
        endcase
        r.cursor_x = cur_col[tcw_pkg::CURSOR_X_W-1:0];
        r.cursor_y = cur_row[tcw_pkg::CURSOR_Y_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_reply();
        t_console_rsp want;
        if (expected_replies.size() == 0) begin
            flag_mismatch($sformatf("unexpected word x=%0d y=%0d data=%h",
                                    rsp_bus.cursor_x, rsp_bus.cursor_y, rsp_bus.cell_data));
            return;
        end
        want = expected_replies.pop_front();
        if (rsp_bus.cursor_x !== want.cursor_x)
            flag_mismatch($sformatf("cursor_x got %0d want %0d", rsp_bus.cursor_x,
                                    want.cursor_x));
        if (rsp_bus.cursor_y !== want.cursor_y)
            flag_mismatch($sformatf("cursor_y got %0d want %0d", rsp_bus.cursor_y,
                                    want.cursor_y));
        if (rsp_bus.cell_data !== want.cell_data)
            flag_mismatch($sformatf("cell_data got %h want %h", rsp_bus.cell_data,
                                    want.cell_data));
    endtask

    // response side: check, then decide ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready)
            check_reply();
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    task automatic send_cmd(input logic [tcw_pkg::OP_W-1:0] op,
                            input logic [tcw_pkg::CHAR_W-1:0] ch,
                            input logic [tcw_pkg::CELL_INDEX_W-1:0] idx, input logic typed,
                            input t_console_rsp typed_rsp);
        t_console_rsp predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.op         <= op;
        cmd_bus.char_code  <= ch;
        cmd_bus.cell_index <= idx;
        do @(posedge i_clk); while (!cmd_bus.ready);
        predicted = console_step(op, ch, idx);
        expected_replies.push_back(typed ? typed_rsp : predicted);
        words_sent++;
        // ignored bytes and the unused op don't count toward the phase quota
        if (!(op == OP_UNUSED || (op == tcw_pkg::OP_PUT && ch != tcw_pkg::CH_BS &&
                                  ch != tcw_pkg::CH_TAB && ch != tcw_pkg::CH_CR &&
                                  ch != tcw_pkg::CH_LF &&
                                  (ch < tcw_pkg::CH_PRINT_LO || ch > tcw_pkg::CH_PRINT_HI))))
            phase_words++;
    endtask

    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [tcw_pkg::CELL_INDEX_W-1:0] any_index();
        return tcw_pkg::CELL_INDEX_W'($urandom_range(2047));
    endfunction

    function automatic logic [tcw_pkg::CHAR_W-1:0] any_printable();
        return tcw_pkg::CHAR_W'($urandom_range(tcw_pkg::CH_PRINT_HI, tcw_pkg::CH_PRINT_LO));
    endfunction

    // one random burst: text lines, line feeds, reads, controls, noise or a clear
    task automatic random_burst();
        int kind;
        int len;
        int r;
        int row;
        kind = $urandom_range(99);
        if (kind < 45) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(100, 60) : $urandom_range(12, 1);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(19);
                if (r == 0)
                    send_cmd(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, any_index(), 1'b0, '0);
                else if (r == 1)
                    send_cmd(tcw_pkg::OP_PUT, tcw_pkg::CH_BS, any_index(), 1'b0, '0);
                else
                    send_cmd(tcw_pkg::OP_PUT, any_printable(), any_index(), 1'b0, '0);
            end
            r = $urandom_range(2);
            if (r == 0)
                send_cmd(tcw_pkg::OP_PUT, tcw_pkg::CH_CR, any_index(), 1'b0, '0);
            if (r != 2)
                send_cmd(tcw_pkg::OP_PUT, tcw_pkg::CH_LF, any_index(), 1'b0, '0);
        end else if (kind < 58) begin
            len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++)
                send_cmd(tcw_pkg::OP_PUT, tcw_pkg::CH_LF, any_index(), 1'b0, '0);
        end else if (kind < 75) begin
            len = $urandom_range(4, 1);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(9);
                row = (cur_row > 0 && $urandom_range(1)) ? cur_row - 1 : cur_row;
                if (r < 7)
                    send_cmd(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom_range(255)),
                             tcw_pkg::CELL_INDEX_W'(row * COLUMNS +
                                                    $urandom_range(COLUMNS - 1)),
                             1'b0, '0);
                else if (r < 9)
                    send_cmd(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom_range(255)),
                             tcw_pkg::CELL_INDEX_W'($urandom_range(CELL_COUNT - 1)),
                             1'b0, '0);
                else
                    send_cmd(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom_range(255)),
                             tcw_pkg::CELL_INDEX_W'($urandom_range(2047, CELL_COUNT)),
                             1'b0, '0);
            end
        end else if (kind < 85) begin
            len = $urandom_range(5, 1);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(2);
                send_cmd(tcw_pkg::OP_PUT,
                         (r == 0) ? tcw_pkg::CH_BS : (r == 1) ? tcw_pkg::CH_TAB : tcw_pkg::CH_CR,
                         any_index(), 1'b0, '0);
            end
        end else if (kind < 97) begin
            r = $urandom_range(3);
            if (r == 0)
                send_cmd(OP_UNUSED, tcw_pkg::CHAR_W'($urandom_range(255)), any_index(),
                         1'b0, '0);
            else if (r == 1)
                send_cmd(tcw_pkg::OP_PUT, tcw_pkg::CHAR_W'($urandom_range(31)), any_index(),
                         1'b0, '0);
            else
                send_cmd(tcw_pkg::OP_PUT, tcw_pkg::CHAR_W'($urandom_range(255)), any_index(),
                         1'b0, '0);
        end else if (kind < 99) begin
            send_cmd(tcw_pkg::OP_CLEAR, tcw_pkg::CHAR_W'($urandom_range(255)), any_index(),
                     1'b0, '0);
        end else begin
            send_cmd(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom_range(255)), any_index(),
                     1'b0, '0);
        end
    endtask

    initial begin
        #40_000_000;
        $display("Timeout with %0d words still expected", expected_replies.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int send_pcts [PHASES];
        int rcv_pcts  [PHASES];
        logic [tcw_pkg::ATTR_W-1:0] attrs [PHASES];

        send_pcts = '{0, 74, 0, 32, 0};
        rcv_pcts  = '{0, 0, 74, 32, 0};
        attrs     = '{8'h00, 8'hFF, 8'h00, 8'hA5, 8'h70};
        attrs[2]  = tcw_pkg::ATTR_W'($urandom_range(255));

        for (int i = 0; i < CELL_COUNT; i++)
            screen_copy[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_BLANK};
        model_attr     = tcw_pkg::RESET_ATTR;
        cur_col        = 0;
        cur_row        = 0;
        mismatch_count = 0;
        words_sent     = 0;
        phase_words    = 0;
        scroll_count   = 0;
        clear_count    = 0;
        read_count     = 0;
        send_idle_pct  = 0;
        rcv_stall_pct  = 0;
        hold_requests  = 0;

        i_rst_n                <= 1'b0;
        cmd_bus.valid          <= 1'b0;
        cmd_bus.op             <= tcw_pkg::OP_PUT;
        cmd_bus.char_code      <= '0;
        cmd_bus.cell_index     <= '0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.text_attribute <= tcw_pkg::RESET_ATTR;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table runs with the reset attribute
        foreach (DIRECTED[i])
            send_cmd(DIRECTED[i].op, DIRECTED[i].ch, DIRECTED[i].idx, DIRECTED[i].typed,
                     DIRECTED[i].rsp);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            cfg_bus.valid          <= 1'b1;
            cfg_bus.text_attribute <= attrs[p];
            do @(posedge i_clk); while (!cfg_bus.ready);
            model_attr = attrs[p];
            cfg_bus.valid <= 1'b0;

            send_idle_pct = send_pcts[p];
            rcv_stall_pct = rcv_pcts[p];
            // last phase: long response hold-off while commands keep coming
            if (p == PHASES - 1)
                hold_requests++;
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                random_burst();
                if (p == PHASES - 1 && phase_words >= PHASE_WORDS / 2 && hold_requests == 1) begin
                    wait_drained();
                    hold_requests++;
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d words over %0d attribute settings:", words_sent, PHASES + 1);
        $display("  %0d scrolls, %0d clears, %0d reads", scroll_count, clear_count,
                 read_count);
        $display("Idle mixes: none, sender 74%%, receiver 74%%, both 32%%, long response hold-off");
        if (mismatch_count == 0 && expected_replies.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
